// ===== rtl/sfp_pkg.sv =====
// Shared types and constants of the SDP fingerprint parser.
package sfp_pkg;

	localparam int FP_BYTES  = 32;
	localparam int FP_BITS   = FP_BYTES * 8;
	localparam int PAD_WORDS = (FP_BYTES + 7) / 8;
	localparam int OUT_WORDS = (PAD_WORDS > 4) ? 4 : PAD_WORDS;
	localparam int PAD_BITS  = PAD_WORDS * 64;
	localparam int PCNT_W    = $clog2(FP_BYTES + 1);
	localparam int REC_DEPTH = 2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] fp_word;
		logic [1:0]  word_index;
		logic        last_word;
	} out_item_t;

	// One finished run as handed from the parser to the word emitter.
	typedef struct packed {
		logic               ok;
		logic [FP_BITS-1:0] fp;
	} run_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rq_stat_t;

endpackage

// ===== rtl/sfp_front.sv =====
// Byte parser: line matching, value syntax check and fingerprint capture.
module sfp_front import sfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	input  logic     config_we,
	input  logic     config_data,
	input  rq_stat_t rq_stat,
	output logic     full,
	output logic     rec_push,
	output run_rec_t rec
);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [3:0] KEY_LEN  = 4'd14;
	localparam logic [3:0] ALG_LEN  = 4'd7;

	typedef enum logic [3:0] {
		PH_KEY, PH_SKIP, PH_KEYDONE, PH_LEAD, PH_TOKEN, PH_MID,
		PH_HI, PH_LO, PH_COLON, PH_TRAIL, PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [3:0]        midx;
		logic [PCNT_W-1:0] pcnt;
		logic [3:0]        hnib;
		logic              cr;
		logic              ok;
	} st_t;

	typedef struct packed {
		st_t        s;
		logic       wr;
		logic [7:0] wbyte;
	} step_t;

	function automatic logic [7:0] key_char(input logic [3:0] i);
		logic [7:0] ch;
		case (i)
			4'd0:    ch = "a";
			4'd1:    ch = "=";
			4'd2:    ch = "f";
			4'd3:    ch = "i";
			4'd4:    ch = "n";
			4'd5:    ch = "g";
			4'd6:    ch = "e";
			4'd7:    ch = "r";
			4'd8:    ch = "p";
			4'd9:    ch = "r";
			4'd10:   ch = "i";
			4'd11:   ch = "n";
			4'd12:   ch = "t";
			4'd13:   ch = ":";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] alg_char(input logic [3:0] i);
		logic [7:0] ch;
		case (i)
			4'd0:    ch = "s";
			4'd1:    ch = "h";
			4'd2:    ch = "a";
			4'd3:    ch = "-";
			4'd4:    ch = "2";
			4'd5:    ch = "5";
			4'd6:    ch = "6";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Bit 4 set means the byte is a hex digit; bits 3:0 give its value.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] n;
		if (c >= "0" && c <= "9") n = {1'b1, 4'(c - "0")};
		else if (c >= "a" && c <= "f") n = {1'b1, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F") n = {1'b1, 4'(c - "A" + 8'd10)};
		else n = 5'd0;
		return n;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB);
	endfunction

	function automatic st_t restart(input logic mode);
		st_t s;
		s.phase = mode ? PH_KEY : PH_LEAD;
		s.midx  = 4'd0;
		s.pcnt  = '0;
		s.hnib  = 4'd0;
		s.cr    = 1'b0;
		s.ok    = 1'b0;
		return s;
	endfunction

	function automatic step_t fail_now(input step_t r);
		step_t o;
		o         = r;
		o.s.ok    = 1'b0;
		o.s.phase = PH_DONE;
		return o;
	endfunction

	function automatic step_t end_value(input step_t r);
		step_t o;
		o         = r;
		o.s.ok    = (r.s.phase == PH_TRAIL);
		o.s.phase = PH_DONE;
		return o;
	endfunction

	function automatic step_t feed_value(input step_t r, input logic [7:0] c);
		step_t      o;
		logic       handled;
		logic [4:0] nb;
		logic [7:0] lc;
		o       = r;
		handled = 1'b0;
		nb      = nibble_of(c);
		lc      = (c >= "A" && c <= "Z") ? (c + 8'd32) : c;
		if (o.s.phase == PH_LEAD) begin
			if (is_blank(c)) begin
				handled = 1'b1;
			end else begin
				o.s.phase = PH_TOKEN;
				o.s.midx  = 4'd0;
			end
		end
		if (!handled && o.s.phase == PH_TOKEN) begin
			handled = 1'b1;
			if (is_blank(c)) begin
				if (o.s.midx == ALG_LEN) o.s.phase = PH_MID;
				else o = fail_now(o);
			end else if (o.s.midx >= ALG_LEN || lc != alg_char(o.s.midx)) begin
				o = fail_now(o);
			end else begin
				o.s.midx = o.s.midx + 4'd1;
			end
		end
		if (!handled && o.s.phase == PH_MID) begin
			if (is_blank(c)) handled = 1'b1;
			else o.s.phase = PH_HI;
		end
		if (!handled && o.s.phase == PH_HI) begin
			handled = 1'b1;
			if (!nb[4]) begin
				o = fail_now(o);
			end else begin
				o.s.hnib  = nb[3:0];
				o.s.phase = PH_LO;
			end
		end
		if (!handled && o.s.phase == PH_LO) begin
			handled = 1'b1;
			if (!nb[4]) begin
				o = fail_now(o);
			end else begin
				if (o.s.pcnt < PCNT_W'(FP_BYTES)) begin
					o.wr    = 1'b1;
					o.wbyte = {o.s.hnib, nb[3:0]};
				end
				o.s.hnib  = 4'd0;
				o.s.pcnt  = o.s.pcnt + PCNT_W'(1);
				o.s.phase = (o.s.pcnt >= PCNT_W'(FP_BYTES)) ? PH_TRAIL : PH_COLON;
			end
		end
		if (!handled && o.s.phase == PH_COLON) begin
			handled = 1'b1;
			if (c != CH_COLON) o = fail_now(o);
			else o.s.phase = PH_HI;
		end
		if (!handled && o.s.phase == PH_TRAIL) begin
			if (!(is_blank(c) || c == CH_CR || c == CH_LF)) o = fail_now(o);
		end
		return o;
	endfunction

	function automatic step_t feed_committed(input step_t r, input logic [7:0] c);
		step_t o;
		o = r;
		if (o.s.phase == PH_KEYDONE) o.s.phase = PH_LEAD;
		return feed_value(o, c);
	endfunction

	function automatic step_t doc_byte(input step_t r, input logic [7:0] c);
		step_t o;
		o = r;
		unique case (r.s.phase)
			PH_KEY: begin
				if (c == CH_LF) begin
					o.s.midx = 4'd0;
				end else if (r.s.midx < KEY_LEN && c == key_char(r.s.midx)) begin
					o.s.midx = r.s.midx + 4'd1;
					if (o.s.midx == KEY_LEN) o.s.phase = PH_KEYDONE;
				end else begin
					o.s.phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (c == CH_LF) begin
					o.s.phase = PH_KEY;
					o.s.midx  = 4'd0;
				end
			end
			PH_DONE: begin
			end
			default: begin
				if (c == CH_LF) begin
					o.s.cr = 1'b0;
					if (o.s.phase == PH_KEYDONE) begin
						o.s.phase = PH_KEY;
						o.s.midx  = 4'd0;
					end else begin
						o = end_value(o);
					end
				end else begin
					// A held CR that is not followed by LF counts as a value byte.
					if (o.s.cr) begin
						o.s.cr = 1'b0;
						o      = feed_committed(o, CH_CR);
					end
					if (o.s.phase != PH_DONE) begin
						if (c == CH_CR) o.s.cr = 1'b1;
						else o = feed_committed(o, c);
					end
				end
			end
		endcase
		return o;
	endfunction

	logic               mode_q;
	st_t                st_q;
	st_t                st_d;
	step_t              nxt;
	step_t              fin;
	logic [FP_BITS-1:0] fp_q;
	logic [FP_BITS-1:0] fp_d;
	logic               accept;

	assign full   = rq_stat.full;
	assign accept = push && !rq_stat.full;

	always_comb begin
		nxt.s     = st_q;
		nxt.wr    = 1'b0;
		nxt.wbyte = 8'h00;
		if (st_q.phase != PH_DONE) begin
			nxt = mode_q ? doc_byte(nxt, item.text_byte) : feed_value(nxt, item.text_byte);
		end
		fin      = nxt;
		fin.s.cr = 1'b0;
		if (fin.s.phase == PH_LEAD || fin.s.phase == PH_TOKEN || fin.s.phase == PH_MID ||
		    fin.s.phase == PH_HI || fin.s.phase == PH_LO || fin.s.phase == PH_COLON ||
		    fin.s.phase == PH_TRAIL) begin
			fin = end_value(fin);
		end else if (fin.s.phase != PH_DONE) begin
			fin = fail_now(fin);
		end
		st_d = item.final_byte ? restart(mode_q) : nxt.s;
	end

	assign fp_d     = nxt.wr ? {fp_q[FP_BITS-9:0], nxt.wbyte} : fp_q;
	assign rec_push = accept && item.final_byte;
	assign rec.ok   = fin.s.ok;
	assign rec.fp   = fp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			st_q   <= restart(1'b1);
		end else if (config_we) begin
			mode_q <= config_data;
			st_q   <= restart(config_data);
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !config_we) fp_q <= fp_d;
	end

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pcnt <= PCNT_W'(FP_BYTES))
		else $error("pair count ran past the fingerprint length");

	a_trail_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_TRAIL) |-> (st_q.pcnt == PCNT_W'(FP_BYTES)))
		else $error("trailing phase reached without a full fingerprint");

endmodule

// ===== rtl/sfp_rec_fifo.sv =====
// Short queue of finished run records between the parser and the emitter.
module sfp_rec_fifo import sfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  run_rec_t wdata,
	input  logic     pop,
	output rq_stat_t stat,
	output run_rec_t rdata
);

	localparam int PTR_W = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
	localparam int CNT_W = $clog2(REC_DEPTH + 1);

	run_rec_t         mem_q [REC_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == CNT_W'(REC_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(REC_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= bump(wptr_q);
			if (do_pop) rptr_q <= bump(rptr_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("record pushed into a full queue");

endmodule

// ===== rtl/sfp_back.sv =====
// Result emitter: splits a run record into fingerprint words.
module sfp_back import sfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rq_stat_t  rq_stat,
	input  run_rec_t  rec,
	input  logic      pop,
	output logic      empty,
	output out_item_t result,
	output logic      rec_pop
);

	logic [1:0]          wcnt_q;
	logic [PAD_BITS-1:0] padded;
	logic                last;

	assign padded = PAD_BITS'(rec.fp) << (PAD_BITS - FP_BITS);
	assign last   = !rec.ok || (wcnt_q == 2'(OUT_WORDS - 1));
	assign empty  = rq_stat.empty;

	assign result.ok         = rec.ok;
	assign result.fp_word    = rec.ok ? padded[PAD_BITS - 64 * (int'(wcnt_q) + 1) +: 64] : 64'd0;
	assign result.word_index = rec.ok ? wcnt_q : 2'd0;
	assign result.last_word  = last;

	assign rec_pop = pop && !rq_stat.empty && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= 2'd0;
		end else if (pop && !rq_stat.empty) begin
			wcnt_q <= last ? 2'd0 : wcnt_q + 2'd1;
		end
	end

	a_wcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= 2'(OUT_WORDS - 1))
		else $error("word counter beyond the last word");

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!rq_stat.empty && !rec.ok) |-> (wcnt_q == 2'd0 && result.fp_word == 64'd0))
		else $error("failed run emitted more than one word");

endmodule

// ===== rtl/sdp_fingerprint_parser_unit.sv =====
// Top level of the SDP sha-256 fingerprint parser.
// Throughput: one text byte per clock unless stalled; a final byte queues its run record.
// A successful run yields four result words (one per pop), a failed run a single result.
// Input stalls (full high) only while the two-entry run record queue is full.
// Reset is asynchronous and active low: document mode is selected, the parser restarts
// and the record queue is emptied; the fingerprint capture register is not reset.
module sdp_fingerprint_parser_unit import sfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result,
	input  logic      config_we,
	input  logic      config_data
);

	// The front end parses one byte per transaction. When it accepts a final byte it
	// hands a complete run record (verdict plus captured fingerprint) to the queue,
	// and it restarts on the next byte without waiting for the emitter.
	rq_stat_t rq_stat;
	run_rec_t rec_in;
	run_rec_t rec_head;
	logic     rec_push;
	logic     rec_pop;

	sfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.config_we  (config_we),
		.config_data(config_data),
		.rq_stat    (rq_stat),
		.full       (full),
		.rec_push   (rec_push),
		.rec        (rec_in)
	);

	// The queue holds finished runs so the front end keeps taking bytes while the
	// back end is still handing out words of an earlier run.
	sfp_rec_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wdata (rec_in),
		.pop   (rec_pop),
		.stat  (rq_stat),
		.rdata (rec_head)
	);

	// The back end walks the oldest record word by word; each pop transaction moves
	// one word, and the record is released after its last word.
	sfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rq_stat(rq_stat),
		.rec    (rec_head),
		.pop    (pop),
		.empty  (empty),
		.result (result),
		.rec_pop(rec_pop)
	);

	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.last_word) |-> rec_pop)
		else $error("last word taken without releasing its record");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the SDP sha-256 fingerprint parser unit.
`timescale 1ns / 1ps

module tb_top;
	import sfp_pkg::*;

	// Byte values that the parser treats specially.
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	// Cycles allowed for bytes still inside the unit once the last result word is out.
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 20;

	// Phases of the scan in the bench's own copy of the parser.
	typedef enum logic [3:0] {
		SCAN_KEY, SCAN_SKIP, SCAN_KEY_SEEN, SCAN_LEAD, SCAN_TOKEN, SCAN_GAP,
		SCAN_HI, SCAN_LO, SCAN_COLON, SCAN_TAIL, SCAN_DONE
	} scan_phase_e;

	typedef enum logic [1:0] {VERDICT_NONE, VERDICT_GOOD, VERDICT_BAD} verdict_e;

	// How a directed text gets its expected words: from the parser copy, or typed in.
	typedef enum logic [1:0] {ROW_PREDICTED, ROW_FAILS, ROW_FILLED} row_check_e;

	typedef struct {
		logic       mode;
		int         offs;
		int         count;
		logic       fin;
		row_check_e chk;
		logic [7:0] fill;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;
	logic      config_we;
	logic      config_data;

	sdp_fingerprint_parser_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.config_we  (config_we),
		.config_data(config_data)
	);

	// Parser copy: mode register and scan state.
	string       key_text = "a=fingerprint:";
	string       alg_text = "sha-256";
	logic        doc_mode_now = 1'b1;
	scan_phase_e scan_phase = SCAN_KEY;
	verdict_e    verdict = VERDICT_NONE;
	int          match_len = 0;
	int          pairs_seen = 0;
	logic [3:0]  hi_nib = '0;
	logic        cr_held = 1'b0;
	logic [7:0]  digest [FP_BYTES];

	// Words the parser copy produced for the latest byte, and the words still owed by the unit.
	out_item_t new_words [$];
	out_item_t words_due [$];

	// Text under construction; the directed table indexes into it.
	logic [7:0] text_buf [$];
	stim_row_t  rows [$];
	int         row_mark = 0;

	int mismatches = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	int words_planned = 0;
	int words_checked = 0;
	int mode_writes = 0;
	int tx_calm = 0;
	int rx_calm = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run limit is far above the slowest legal run of the stimulus below.
	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
	endtask

	// Idle length for either side: mostly none, some short, a few long, and every
	// now and then a calm stretch with no idling at all.
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB;
	endfunction

	function automatic int hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void restart_scan();
		scan_phase = doc_mode_now ? SCAN_KEY : SCAN_LEAD;
		match_len = 0;
		pairs_seen = 0;
		hi_nib = '0;
		cr_held = 1'b0;
		verdict = VERDICT_NONE;
	endfunction

	function automatic void give_up();
		verdict = VERDICT_BAD;
		scan_phase = SCAN_DONE;
	endfunction

	// The value is over: only a value that got through all pairs passes.
	function automatic void close_value();
		verdict = (scan_phase == SCAN_TAIL) ? VERDICT_GOOD : VERDICT_BAD;
		scan_phase = SCAN_DONE;
	endfunction

	// One byte of the attribute value itself.
	function automatic void value_byte(input logic [7:0] ch);
		logic [7:0] c;
		int n;
		c = ch;
		// Leading blanks are skipped; the first other byte opens the token.
		if (scan_phase == SCAN_LEAD) begin
			if (is_blank(c)) return;
			scan_phase = SCAN_TOKEN;
			match_len = 0;
		end
		// Blanks between the token and the first pair.
		if (scan_phase == SCAN_GAP) begin
			if (is_blank(c)) return;
			scan_phase = SCAN_HI;
		end
		n = hex_val(c);
		case (scan_phase)
			SCAN_TOKEN: begin
				if (is_blank(c)) begin
					if (match_len == alg_text.len()) scan_phase = SCAN_GAP;
					else give_up();
				end else begin
					if (c >= "A" && c <= "Z") c = c + 8'd32;
					if (match_len >= alg_text.len() || c != alg_text[match_len]) give_up();
					else match_len++;
				end
			end
			SCAN_HI: begin
				if (n < 0) give_up();
				else begin
					hi_nib = n[3:0];
					scan_phase = SCAN_LO;
				end
			end
			SCAN_LO: begin
				if (n < 0) give_up();
				else begin
					if (pairs_seen < FP_BYTES) digest[pairs_seen] = {hi_nib, n[3:0]};
					pairs_seen++;
					scan_phase = (pairs_seen >= FP_BYTES) ? SCAN_TAIL : SCAN_COLON;
				end
			end
			SCAN_COLON: begin
				if (c != ":") give_up();
				else scan_phase = SCAN_HI;
			end
			SCAN_TAIL: begin
				if (!(is_blank(c) || c == CH_CR || c == CH_LF)) give_up();
			end
			default: ;
		endcase
	endfunction

	function automatic void value_committed(input logic [7:0] c);
		if (scan_phase == SCAN_KEY_SEEN) scan_phase = SCAN_LEAD;
		value_byte(c);
	endfunction

	// One byte in document mode: line keying, then the value of the deciding line.
	function automatic void line_byte(input logic [7:0] c);
		case (scan_phase)
			SCAN_KEY: begin
				if (c == CH_LF) match_len = 0;
				else if (match_len < key_text.len() && c == key_text[match_len]) begin
					match_len++;
					if (match_len == key_text.len()) scan_phase = SCAN_KEY_SEEN;
				end else scan_phase = SCAN_SKIP;
			end
			SCAN_SKIP: begin
				if (c == CH_LF) begin
					scan_phase = SCAN_KEY;
					match_len = 0;
				end
			end
			SCAN_DONE: ;
			default: begin
				if (c == CH_LF) begin
					cr_held = 1'b0;
					// A key with nothing after it does not make the line decide.
					if (scan_phase == SCAN_KEY_SEEN) begin
						scan_phase = SCAN_KEY;
						match_len = 0;
					end else close_value();
				end else begin
					// A held CR that is not followed by LF is an ordinary value byte.
					if (cr_held) begin
						cr_held = 1'b0;
						value_committed(CH_CR);
						if (scan_phase == SCAN_DONE) return;
					end
					if (c == CH_CR) cr_held = 1'b1;
					else value_committed(c);
				end
			end
		endcase
	endfunction

	// Advance the parser copy by one accepted byte; a final byte leaves its words in new_words.
	function automatic void parse_step(input logic [7:0] c, input logic fin);
		logic [63:0] word;
		int idx;
		new_words.delete();
		if (scan_phase != SCAN_DONE) begin
			if (doc_mode_now) line_byte(c);
			else value_byte(c);
		end
		if (!fin) return;
		cr_held = 1'b0;
		if (scan_phase >= SCAN_LEAD && scan_phase <= SCAN_TAIL) close_value();
		else if (scan_phase != SCAN_DONE) give_up();
		if (verdict == VERDICT_GOOD) begin
			for (int w = 0; w < OUT_WORDS; w++) begin
				word = '0;
				for (int b = 0; b < 8; b++) begin
					idx = w * 8 + b;
					word = {word[55:0], (idx < FP_BYTES) ? digest[idx] : 8'h00};
				end
				new_words.push_back('{ok: 1'b1, fp_word: word, word_index: 2'(w),
					last_word: (w == OUT_WORDS - 1)});
			end
		end else begin
			new_words.push_back('{ok: 1'b0, fp_word: '0, word_index: '0, last_word: 1'b1});
		end
		restart_scan();
	endfunction

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	task automatic put_eol();
		if ($urandom_range(0, 1)) text_buf.push_back(CH_CR);
		text_buf.push_back(CH_LF);
	endtask

	// Colon-separated hex pairs, either all equal to fill or random, in mixed case.
	task automatic put_pairs(input logic [7:0] fill, input logic rnd, input int n);
		logic [7:0] v;
		for (int i = 0; i < n; i++) begin
			if (i > 0) text_buf.push_back(":");
			v = rnd ? 8'($urandom_range(0, 255)) : fill;
			if ($urandom_range(0, 1)) put_str($sformatf("%02X", v));
			else put_str($sformatf("%02x", v));
		end
	endtask

	task automatic close_row(input logic m, input logic fin, input row_check_e chk,
			input logic [7:0] fill);
		rows.push_back('{mode: m, offs: row_mark, count: text_buf.size() - row_mark,
			fin: fin, chk: chk, fill: fill});
		row_mark = text_buf.size();
	endtask

	// Write the mode register. Only done with nothing owed by the unit and with the
	// last bytes given time to settle, so this also holds the sender off until the
	// unit has drained.
	task automatic set_mode(input logic m);
		push <= 1'b0;
		while (words_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		config_we <= 1'b1;
		config_data <= m;
		@(negedge clk);
		config_we <= 1'b0;
		doc_mode_now = m;
		restart_scan();
		mode_writes++;
	endtask

	// Offer one byte, wait for the transaction, then book the words it will cause.
	task automatic send_byte(input logic [7:0] b, input logic fin, input row_check_e chk,
			input logic [7:0] fill);
		int gap;
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= '{text_byte: b, final_byte: fin};
		do @(posedge clk); while (full);
		parse_step(b, fin);
		if (fin) begin
			if (chk == ROW_FAILS) begin
				words_due.push_back('{ok: 1'b0, fp_word: '0, word_index: '0, last_word: 1'b1});
				words_planned++;
			end else if (chk == ROW_FILLED) begin
				for (int w = 0; w < OUT_WORDS; w++)
					words_due.push_back('{ok: 1'b1, fp_word: {8{fill}}, word_index: 2'(w),
						last_word: (w == OUT_WORDS - 1)});
				words_planned += OUT_WORDS;
			end else begin
				foreach (new_words[k]) words_due.push_back(new_words[k]);
				words_planned += new_words.size();
			end
			texts_sent++;
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	// One random text. Many are well-formed values with random content (wrapped in
	// session description lines in document mode); the rest are raw noise, values
	// cut off at a random point, a wrong pair count or one corrupted byte.
	task automatic make_run();
		int kind;
		int n;
		int cut;
		logic [7:0] ch;
		kind = $urandom_range(0, 99);
		text_buf.delete();
		if (kind >= 60 && kind < 80) begin
			n = $urandom_range(1, 12);
			repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (doc_mode_now) begin
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 3))
					0: put_str("v=0");
					1: put_str("a=fingerprint:");
					2: put_str("a=fingerprinx:sha-256");
					default: put_str("a=fingerprint");
				endcase
				put_eol();
			end
			put_str(key_text);
		end
		repeat ($urandom_range(0, 2)) text_buf.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
		for (int i = 0; i < alg_text.len(); i++) begin
			ch = alg_text[i];
			if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
			text_buf.push_back(ch);
		end
		repeat ($urandom_range(1, 2)) text_buf.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
		n = FP_BYTES;
		if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1) ? FP_BYTES - 1 : FP_BYTES + 1;
		put_pairs(8'h00, 1'b1, n);
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 3))
				0: text_buf.push_back(CH_SP);
				1: text_buf.push_back(CH_TAB);
				2: text_buf.push_back(CH_CR);
				default: text_buf.push_back(CH_LF);
			endcase
		end
		if (doc_mode_now && $urandom_range(0, 1)) begin
			put_eol();
			put_str("a=fingerprint:junk");
		end
		if ($urandom_range(0, 5) == 0)
			text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
		if (kind >= 80) begin
			cut = $urandom_range(1, text_buf.size());
			while (text_buf.size() > cut) void'(text_buf.pop_back());
		end
	endtask

	// Result side: pop with random stalls, most short, a few long, some calm stretches.
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = idle_len(rx_calm);
			end
		end
	end

	// Every result transaction is held against the oldest word still owed.
	always @(posedge clk) begin : word_check
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (words_due.size() == 0) begin
				flag("result word arrived with none expected");
			end else begin
				want = words_due.pop_front();
				words_checked++;
				if (result.ok !== want.ok)
					flag($sformatf("ok got %0b want %0b", result.ok, want.ok));
				if (result.fp_word !== want.fp_word)
					flag($sformatf("fp_word got %h want %h", result.fp_word, want.fp_word));
				if (result.word_index !== want.word_index)
					flag($sformatf("word_index got %0d want %0d", result.word_index,
						want.word_index));
				if (result.last_word !== want.last_word)
					flag($sformatf("last_word got %0b want %0b", result.last_word,
						want.last_word));
			end
		end
	end

	initial begin
		int rand_bytes0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		config_we = 1'b0;
		config_data = 1'b0;
		foreach (digest[i]) digest[i] = 8'h00;
		restart_scan();

		// Directed table. Rows with an obvious outcome carry it typed in; the
		// others are checked against the parser copy.

		// A document with no fingerprint line fails.
		put_str("v=0\n");
		close_row(1'b1, 1'b1, ROW_FAILS, 8'h00);
		// All-zero fingerprint, line ended by CR LF.
		put_str("a=fingerprint:sha-256 ");
		put_pairs(8'h00, 1'b0, FP_BYTES);
		text_buf.push_back(CH_CR);
		text_buf.push_back(CH_LF);
		close_row(1'b1, 1'b1, ROW_FILLED, 8'h00);
		// An empty key line does not decide; all-ones value with a CR right at the end.
		put_str("a=fingerprint:\na=fingerprint:sha-256\t");
		put_pairs(8'hFF, 1'b0, FP_BYTES);
		text_buf.push_back(CH_CR);
		close_row(1'b1, 1'b1, ROW_FILLED, 8'hFF);
		// The first deciding line fails, so the good line after it is ignored.
		put_str("a=fingerprint:sha-256 zz\na=fingerprint:sha-256 ");
		put_pairs(8'h00, 1'b1, FP_BYTES);
		put_str("\n");
		close_row(1'b1, 1'b1, ROW_FAILS, 8'h00);
		// Near-miss key, then a good line in upper case, then extreme bytes that are ignored.
		put_str("a=fingerprinx:q\na=fingerprint: SHA-256 ");
		put_pairs(8'h00, 1'b1, FP_BYTES);
		put_str("\n");
		text_buf.push_back(8'hFF);
		text_buf.push_back(8'h00);
		close_row(1'b1, 1'b1, ROW_PREDICTED, 8'h00);
		// A CR not followed by LF is part of the value and spoils the token.
		put_str("a=fingerprint:sha-256");
		text_buf.push_back(CH_CR);
		put_str(" 00\n");
		close_row(1'b1, 1'b1, ROW_FAILS, 8'h00);
		// Blanks only: the token is empty.
		put_str("a=fingerprint: \t\n");
		close_row(1'b1, 1'b1, ROW_FAILS, 8'h00);
		// One pair too many.
		put_str("a=fingerprint:sha-256 ");
		put_pairs(8'h00, 1'b1, FP_BYTES + 1);
		put_str("\n");
		close_row(1'b1, 1'b1, ROW_FAILS, 8'h00);
		// Bad separator, bad hex digit.
		put_str("a=fingerprint:sha-256 00;11\n");
		close_row(1'b1, 1'b1, ROW_FAILS, 8'h00);
		put_str("a=fingerprint:sha-256 0g\n");
		close_row(1'b1, 1'b1, ROW_FAILS, 8'h00);
		// A run left open; the mode write that follows restarts it.
		put_str("a=fingerprint:sha");
		close_row(1'b1, 1'b0, ROW_PREDICTED, 8'h00);
		// Attribute mode: CR and LF are plain trailing bytes.
		put_str("\tShA-256 ");
		put_pairs(8'h00, 1'b1, FP_BYTES);
		text_buf.push_back(CH_CR);
		text_buf.push_back(CH_LF);
		put_str(" \t");
		close_row(1'b0, 1'b1, ROW_PREDICTED, 8'h00);
		// Attribute mode: a leading LF opens the token and fails it.
		put_str("\nsha-256 00");
		close_row(1'b0, 1'b1, ROW_FAILS, 8'h00);
		// Token one byte too long.
		put_str("sha-2560 ab");
		close_row(1'b0, 1'b1, ROW_FAILS, 8'h00);
		// Extreme bytes: the first fails the token, the final one is ignored.
		text_buf.push_back(8'hFF);
		text_buf.push_back(8'h00);
		close_row(1'b0, 1'b1, ROW_FAILS, 8'h00);
		// One pair short.
		put_str("sha-256 ");
		put_pairs(8'h00, 1'b1, FP_BYTES - 1);
		close_row(1'b0, 1'b1, ROW_FAILS, 8'h00);
		// Document mode again: the end of the text closes the value.
		put_str("a=fingerprint:sha-256 ");
		put_pairs(8'h00, 1'b1, FP_BYTES);
		close_row(1'b1, 1'b1, ROW_PREDICTED, 8'h00);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].mode != doc_mode_now) set_mode(rows[i].mode);
			for (int j = 0; j < rows[i].count; j++)
				send_byte(text_buf[rows[i].offs + j], rows[i].fin && (j == rows[i].count - 1),
					rows[i].chk, rows[i].fill);
		end

		// Random texts in both modes. The mode is rewritten now and then, each time
		// after the unit has delivered every word it owes.
		set_mode(1'($urandom_range(0, 1)));
		rand_bytes0 = bytes_sent;
		while (bytes_sent - rand_bytes0 < 220) begin
			if ($urandom_range(0, 5) == 0) set_mode(1'($urandom_range(0, 1)));
			make_run();
			for (int j = 0; j < text_buf.size(); j++)
				send_byte(text_buf[j], j == text_buf.size() - 1, ROW_PREDICTED, 8'h00);
		end

		// Stop offering bytes, collect every owed word, then watch for strays.
		push <= 1'b0;
		while (words_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("summary: %0d bytes in %0d texts (%0d directed rows), %0d mode writes",
			bytes_sent, texts_sent, rows.size(), mode_writes);
		$display("summary: %0d of %0d result words checked, %0d mismatches",
			words_checked, words_planned, mismatches);
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sfp_pkg.sv
rtl/sfp_front.sv
rtl/sfp_rec_fifo.sv
rtl/sfp_back.sv
rtl/sdp_fingerprint_parser_unit.sv
bench/tb_top.sv
